FILE: design/mwm_pkg.sv
// ---------------------------------------------------------------------------
// mwm_pkg : maze wall map tracker package
// Request and result types, wall and side codes, microprogram control
// words and the microcode store shared by the tracker.
// ---------------------------------------------------------------------------
package mwm_pkg;

    // default maze size
    localparam int MAZE_WIDTH_DEF  = 16;
    localparam int MAZE_HEIGHT_DEF = 16;

    // wall state codes
    localparam logic [1:0] WS_UNKNOWN = 2'd0;
    localparam logic [1:0] WS_OPEN    = 2'd1;
    localparam logic [1:0] WS_WALL    = 2'd2;

    // compass sides
    localparam logic [1:0] SIDE_N = 2'd0;
    localparam logic [1:0] SIDE_E = 2'd1;
    localparam logic [1:0] SIDE_S = 2'd2;
    localparam logic [1:0] SIDE_W = 2'd3;

    // sides relative to the heading
    localparam logic [1:0] REL_FRONT = 2'd0;
    localparam logic [1:0] REL_RIGHT = 2'd1;
    localparam logic [1:0] REL_BACK  = 2'd2;
    localparam logic [1:0] REL_LEFT  = 2'd3;

    // command codes
    localparam logic [2:0] CMD_SENSE = 3'd0;
    localparam logic [2:0] CMD_MOVE  = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_INIT  = 3'd3;
    localparam logic [2:0] CMD_HOME  = 3'd4;

    typedef struct packed {
        logic [2:0] command;
        logic       wall_front;
        logic       wall_right;
        logic       wall_left;
        logic [1:0] next_heading;
        logic [3:0] read_x;
        logic [3:0] read_y;
    } request_t;

    typedef struct packed {
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [1:0] heading;
        logic [1:0] north_wall;
        logic [1:0] east_wall;
        logic [1:0] south_wall;
        logic [1:0] west_wall;
    } result_t;

    // address sources for the map ram
    typedef enum logic [2:0] {
        ADR_CUR   = 3'd0,
        ADR_N     = 3'd1,
        ADR_E     = 3'd2,
        ADR_S     = 3'd3,
        ADR_W     = 3'd4,
        ADR_RDXY  = 3'd5,
        ADR_SWEEP = 3'd6
    } adr_sel_t;

    typedef enum logic [1:0] {
        POSE_NONE = 2'd0,
        POSE_MOVE = 2'd1,
        POSE_HOME = 2'd2
    } pose_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT  = 2'd0,
        SEQ_JUMP  = 2'd1,
        SEQ_SWEEP = 2'd2,
        SEQ_END   = 2'd3
    } seq_op_t;

    localparam int PC_W = 4;

    // microprogram entry points
    localparam logic [PC_W-1:0] PC_SENSE = 4'd0;
    localparam logic [PC_W-1:0] PC_OUT   = 4'd5;
    localparam logic [PC_W-1:0] PC_MOVE  = 4'd6;
    localparam logic [PC_W-1:0] PC_RDCUR = 4'd7;
    localparam logic [PC_W-1:0] PC_HOME  = 4'd8;
    localparam logic [PC_W-1:0] PC_READ  = 4'd9;
    localparam logic [PC_W-1:0] PC_INIT  = 4'd10;
    localparam logic [PC_W-1:0] PC_LAST  = 4'd11;

    typedef struct packed {
        logic              rd_en;
        adr_sel_t          rd_src;
        logic              wr_en;
        adr_sel_t          wr_src;
        pose_op_t          pose;
        seq_op_t           seq;
        logic [PC_W-1:0]   target;
    } ctrl_word_t;

    localparam ctrl_word_t CW_NOP = '{
        rd_en:  1'b0,
        rd_src: ADR_CUR,
        wr_en:  1'b0,
        wr_src: ADR_CUR,
        pose:   POSE_NONE,
        seq:    SEQ_NEXT,
        target: PC_OUT
    };

    // microcode store
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t cw;
        cw = CW_NOP;
        unique case (pc)
            // sense: write own cell, then patch the four neighbours
            4'd0:
            begin
                cw.wr_en = 1'b1; cw.wr_src = ADR_CUR;
                cw.rd_en = 1'b1; cw.rd_src = ADR_N;
            end
            4'd1:
            begin
                cw.wr_en = 1'b1; cw.wr_src = ADR_N;
                cw.rd_en = 1'b1; cw.rd_src = ADR_E;
            end
            4'd2:
            begin
                cw.wr_en = 1'b1; cw.wr_src = ADR_E;
                cw.rd_en = 1'b1; cw.rd_src = ADR_S;
            end
            4'd3:
            begin
                cw.wr_en = 1'b1; cw.wr_src = ADR_S;
                cw.rd_en = 1'b1; cw.rd_src = ADR_W;
            end
            4'd4:
            begin
                cw.wr_en = 1'b1; cw.wr_src = ADR_W;
                cw.rd_en = 1'b1; cw.rd_src = ADR_CUR;
            end
            // shared result step
            4'd5:
            begin
                cw.seq = SEQ_END;
            end
            4'd6:
            begin
                cw.pose = POSE_MOVE;
            end
            4'd7:
            begin
                cw.rd_en = 1'b1; cw.rd_src = ADR_CUR;
                cw.seq = SEQ_JUMP; cw.target = PC_OUT;
            end
            4'd8:
            begin
                cw.pose = POSE_HOME;
                cw.seq = SEQ_JUMP; cw.target = PC_RDCUR;
            end
            4'd9:
            begin
                cw.rd_en = 1'b1; cw.rd_src = ADR_RDXY;
                cw.seq = SEQ_JUMP; cw.target = PC_OUT;
            end
            // init: one cell a step over the whole map
            4'd10:
            begin
                cw.wr_en = 1'b1; cw.wr_src = ADR_SWEEP;
                cw.seq = SEQ_SWEEP;
            end
            4'd11:
            begin
                cw.pose = POSE_HOME;
                cw.seq = SEQ_JUMP; cw.target = PC_RDCUR;
            end
            default:
            begin
                cw.seq = SEQ_END;
            end
        endcase
        return cw;
    endfunction

    // initial wall pattern of one cell
    function automatic logic [7:0] init_cell(input int x, input int y,
                                             input int w, input int h);
        logic [1:0] n;
        logic [1:0] e;
        logic [1:0] s;
        logic [1:0] wst;
        n   = WS_UNKNOWN;
        e   = WS_UNKNOWN;
        s   = WS_UNKNOWN;
        wst = WS_UNKNOWN;
        if (y == h - 1) n = WS_WALL;
        if (x == 0 && y == 0) n = WS_OPEN;
        if (x == w - 1 || (x == 0 && y == 0)) e = WS_WALL;
        if (y == 0) s = WS_WALL;
        if (x == 0 || (x == 1 && y == 0)) wst = WS_WALL;
        return {wst, s, e, n};
    endfunction

endpackage

FILE: design/mwm_ram.sv
// ---------------------------------------------------------------------------
// mwm_ram : generic simple dual-port ram
// One write port and one read port, read data registered on read enable.
// ---------------------------------------------------------------------------
module mwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/maze_wall_map_tracker_unit.sv
// ---------------------------------------------------------------------------
// maze_wall_map_tracker_unit : wall map and pose tracker for a square maze
//
// A request is taken at a rising edge with start high and busy low. Each
// request gives one result: done is high for one cycle with result holding
// the pose and the four wall states of the reported cell (the read cell for
// a read, otherwise the robot's cell). The receiver cannot hold results off.
// Control runs from a small microprogram; all map traffic goes through one
// ram with one write and one registered read port.
// Busy falls in the cycle that done is shown. A sense does an own cell
// write and four neighbour read-modify-writes; init writes one map cell
// per cycle. A new request may be taken in the cycle that done is shown.
// After reset the unit runs the init program quietly: busy stays high
// while it runs and no result is given.
// ---------------------------------------------------------------------------
module maze_wall_map_tracker_unit #(
    parameter int MAZE_WIDTH  = mwm_pkg::MAZE_WIDTH_DEF,
    parameter int MAZE_HEIGHT = mwm_pkg::MAZE_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mwm_pkg::request_t request,
    output logic              done,
    output mwm_pkg::result_t  result
);

    import mwm_pkg::*;

    localparam int XW    = $clog2(MAZE_WIDTH);
    localparam int YW    = $clog2(MAZE_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    // control and pose state
    logic            busy_reg,  busy_next;
    logic            quiet_reg, quiet_next;
    logic            done_reg,  done_next;
    logic            rd_ok_reg, rd_ok_next;
    logic [PC_W-1:0] pc_reg,    pc_next;
    logic [XW-1:0]   x_reg,     x_next;
    logic [YW-1:0]   y_reg,     y_next;
    logic [1:0]      head_reg,  head_next;
    logic [XW-1:0]   sweep_x_reg, sweep_x_next;
    logic [YW-1:0]   sweep_y_reg, sweep_y_next;

    // payload
    request_t        req_reg,   req_next;
    result_t         result_reg, result_next;

    ctrl_word_t      cw;
    logic            accept;
    logic            sweep_last;
    logic [1:0]      side_code [4];
    logic            ok_n, ok_e, ok_s, ok_w;
    logic [AW-1:0]   adr_cur, adr_n, adr_e, adr_s, adr_w, adr_rdxy, adr_sweep;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [7:0]      ram_wdata, ram_rdata;
    logic [7:0]      walls;

    assign accept = start && !busy_reg;
    assign cw     = ucode(pc_reg);
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // compass wall codes from the sensed relative walls
    always_comb
    begin
        logic [1:0] rel;
        for (int s = 0; s < 4; s++)
        begin
            rel = 2'(s) - head_reg;
            unique case (rel)
                REL_FRONT: side_code[s] = req_reg.wall_front ? WS_WALL : WS_OPEN;
                REL_RIGHT: side_code[s] = req_reg.wall_right ? WS_WALL : WS_OPEN;
                REL_BACK:  side_code[s] = WS_OPEN;
                REL_LEFT:  side_code[s] = req_reg.wall_left ? WS_WALL : WS_OPEN;
                default:   side_code[s] = WS_OPEN;
            endcase
        end
    end

    // neighbour range checks and cell addresses
    assign ok_n = (y_reg != YW'(MAZE_HEIGHT - 1));
    assign ok_e = (x_reg != XW'(MAZE_WIDTH - 1));
    assign ok_s = (y_reg != '0);
    assign ok_w = (x_reg != '0);

    assign adr_cur   = {y_reg, x_reg};
    assign adr_n     = {YW'(y_reg + 1'b1), x_reg};
    assign adr_e     = {y_reg, XW'(x_reg + 1'b1)};
    assign adr_s     = {YW'(y_reg - 1'b1), x_reg};
    assign adr_w     = {y_reg, XW'(x_reg - 1'b1)};
    assign adr_rdxy  = {YW'(req_reg.read_y), XW'(req_reg.read_x)};
    assign adr_sweep = {sweep_y_reg, sweep_x_reg};

    // read port
    always_comb
    begin
        ram_re = busy_reg && cw.rd_en;
        unique case (cw.rd_src)
            ADR_N:     ram_raddr = adr_n;
            ADR_E:     ram_raddr = adr_e;
            ADR_S:     ram_raddr = adr_s;
            ADR_W:     ram_raddr = adr_w;
            ADR_RDXY:  ram_raddr = adr_rdxy;
            ADR_SWEEP: ram_raddr = adr_sweep;
            default:   ram_raddr = adr_cur;
        endcase
    end

    // write port: full cell, neighbour patch or init pattern
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = adr_cur;
        ram_wdata = {side_code[SIDE_W], side_code[SIDE_S],
                     side_code[SIDE_E], side_code[SIDE_N]};
        unique case (cw.wr_src)
            ADR_N:
            begin
                ram_we    = ok_n;
                ram_waddr = adr_n;
                ram_wdata = {ram_rdata[7:6], side_code[SIDE_N], ram_rdata[3:0]};
            end
            ADR_E:
            begin
                ram_we    = ok_e;
                ram_waddr = adr_e;
                ram_wdata = {side_code[SIDE_E], ram_rdata[5:0]};
            end
            ADR_S:
            begin
                ram_we    = ok_s;
                ram_waddr = adr_s;
                ram_wdata = {ram_rdata[7:2], side_code[SIDE_S]};
            end
            ADR_W:
            begin
                ram_we    = ok_w;
                ram_waddr = adr_w;
                ram_wdata = {ram_rdata[7:4], side_code[SIDE_W], ram_rdata[1:0]};
            end
            ADR_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = adr_sweep;
                ram_wdata = init_cell(int'(sweep_x_reg), int'(sweep_y_reg),
                                      MAZE_WIDTH, MAZE_HEIGHT);
            end
            default:
            begin
                ram_we = 1'b1;
            end
        endcase
        ram_we = ram_we && busy_reg && cw.wr_en;
    end

    mwm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sweep_last = (sweep_x_reg == XW'(MAZE_WIDTH - 1))
                     && (sweep_y_reg == YW'(MAZE_HEIGHT - 1));
    assign walls      = rd_ok_reg ? ram_rdata : 8'd0;

    // sequencer, pose update and result capture
    always_comb
    begin
        busy_next    = busy_reg;
        quiet_next   = quiet_reg;
        done_next    = 1'b0;
        rd_ok_next   = rd_ok_reg;
        pc_next      = pc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        head_next    = head_reg;
        sweep_x_next = sweep_x_reg;
        sweep_y_next = sweep_y_reg;
        req_next     = req_reg;
        result_next  = result_reg;

        if (!busy_reg)
        begin
            // dispatch a new request to its program
            if (start)
            begin
                req_next   = request;
                busy_next  = 1'b1;
                rd_ok_next = (request.command != CMD_READ)
                          || ((int'(request.read_x) < MAZE_WIDTH)
                           && (int'(request.read_y) < MAZE_HEIGHT));
                unique case (request.command)
                    CMD_SENSE: pc_next = PC_SENSE;
                    CMD_MOVE:  pc_next = PC_MOVE;
                    CMD_READ:  pc_next = PC_READ;
                    CMD_INIT:  pc_next = PC_INIT;
                    CMD_HOME:  pc_next = PC_HOME;
                    default:   pc_next = PC_RDCUR;
                endcase
            end
        end
        else
        begin
            // pose operation of this step
            unique case (cw.pose)
                POSE_MOVE:
                begin
                    head_next = req_reg.next_heading;
                    unique case (req_reg.next_heading)
                        SIDE_N:  if (ok_n) y_next = YW'(y_reg + 1'b1);
                        SIDE_E:  if (ok_e) x_next = XW'(x_reg + 1'b1);
                        SIDE_S:  if (ok_s) y_next = YW'(y_reg - 1'b1);
                        default: if (ok_w) x_next = XW'(x_reg - 1'b1);
                    endcase
                end
                POSE_HOME:
                begin
                    x_next    = '0;
                    y_next    = '0;
                    head_next = SIDE_N;
                end
                default:
                begin
                end
            endcase

            // step counter
            unique case (cw.seq)
                SEQ_NEXT:
                begin
                    pc_next = PC_W'(pc_reg + 1'b1);
                end
                SEQ_JUMP:
                begin
                    pc_next = cw.target;
                end
                SEQ_SWEEP:
                begin
                    if (sweep_last)
                    begin
                        sweep_x_next = '0;
                        sweep_y_next = '0;
                        pc_next      = PC_W'(pc_reg + 1'b1);
                    end
                    else if (sweep_x_reg == XW'(MAZE_WIDTH - 1))
                    begin
                        sweep_x_next = '0;
                        sweep_y_next = YW'(sweep_y_reg + 1'b1);
                    end
                    else
                    begin
                        sweep_x_next = XW'(sweep_x_reg + 1'b1);
                    end
                end
                default:
                begin
                    busy_next               = 1'b0;
                    quiet_next              = 1'b0;
                    done_next               = !quiet_reg;
                    result_next.pos_x       = 4'(x_reg);
                    result_next.pos_y       = 4'(y_reg);
                    result_next.heading     = head_reg;
                    result_next.north_wall  = walls[1:0];
                    result_next.east_wall   = walls[3:2];
                    result_next.south_wall  = walls[5:4];
                    result_next.west_wall   = walls[7:6];
                end
            endcase
        end
    end

    // control registers, reset starts the quiet init program
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            quiet_reg   <= 1'b1;
            done_reg    <= 1'b0;
            rd_ok_reg   <= 1'b1;
            pc_reg      <= PC_INIT;
            x_reg       <= '0;
            y_reg       <= '0;
            head_reg    <= SIDE_N;
            sweep_x_reg <= '0;
            sweep_y_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            quiet_reg   <= quiet_next;
            done_reg    <= done_next;
            rd_ok_reg   <= rd_ok_next;
            pc_reg      <= pc_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            head_reg    <= head_next;
            sweep_x_reg <= sweep_x_next;
            sweep_y_reg <= sweep_y_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    // a result only follows a cycle of program execution
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("result strobe without a running program");

    // the init sweep always leaves its counters at the origin
    a_sweep_parked: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (sweep_x_reg == '0 && sweep_y_reg == '0))
        else $error("sweep counters not parked while idle");

    // robot stays inside the maze
    a_pose_in_maze: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(x_reg) < MAZE_WIDTH) && (int'(y_reg) < MAZE_HEIGHT))
        else $error("robot position outside the maze");

    // the step counter never leaves the program
    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= PC_LAST))
        else $error("step counter beyond the microprogram");
`endif

endmodule
